// File: rtl/tti_pkg.sv
// Shared constants of the thermistor table interpolator.
package tti_pkg;

	localparam int SAMPLE_BITS = 14;
	localparam int TEMP_BITS   = 16;
	localparam int ENTRY_W     = SAMPLE_BITS + TEMP_BITS;

	localparam int IN_DATA_W   = 56;
	localparam int OUT_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;

	localparam logic [1:0] MODE_FIXED   = 2'd0;
	localparam logic [1:0] MODE_TABLE   = 2'd1;
	localparam logic [1:0] MODE_LINEAR  = 2'd2;
	localparam logic [1:0] MODE_QUARTER = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 2'd3;

	localparam logic [0:0] KIND_WRITE   = 1'b0;
	localparam logic [0:0] KIND_CONVERT = 1'b1;

	localparam logic signed [TEMP_BITS-1:0] FIXED_EIGHTHS = 16'sd200;
	localparam logic signed [TEMP_BITS-1:0] TEMP_MAX      = 16'sh7fff;
	localparam logic signed [TEMP_BITS-1:0] TEMP_MIN      = 16'sh8000;

	localparam int PROD_W = 32;
	localparam int DIV_CNT_W = 5;

endpackage

// File: rtl/thermistor_table_interpolator_top.sv
// Thermistor table interpolator: table walk, linear scaling, fixed and quarter-degree modes.
//
// channel  | signals                               | payload
// ---------+---------------------------------------+----------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser     | tuser kind; tdata index,raw,temp,sample
// output   | m_tvalid m_tready m_tdata m_tuser     | tdata temp_eighths; tuser off_table
// config   | cfg_valid cfg_ready cfg_index cfg_data| register index and value
//
// A table conversion walks the table one entry per cycle, then multiplies, runs 32 divide
// steps, saturates and goes to the output stage; off the table or on equal raw neighbours it
// goes there straight, as fixed and quarter-degree do; linear scales first; a table write stays idle.
// The input is ready only while the sequencer is idle, again from the cycle in which m_tvalid
// rises; a finished result waits in the sequencer until the output register is free.
// Reset clears control state, sets the config registers to their defaults; the table memory is undefined until written.
module thermistor_table_interpolator_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [5:0] entry_index, [19:6] entry_raw, [35:20] entry_temp, [49:36] raw_sample
	input  logic [tti_pkg::IN_DATA_W-1:0]     s_tdata,
	// [0] kind
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] temp_eighths
	output logic [tti_pkg::OUT_DATA_W-1:0]    m_tdata,
	// [0] off_table
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tti_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW = tti_pkg::SAMPLE_BITS;
	localparam int TW = tti_pkg::TEMP_BITS;
	localparam int EW = tti_pkg::ENTRY_W;
	localparam int PW = tti_pkg::PROD_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_LIN   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]  state_q;
	logic [1:0]  mode_q;
	logic [6:0]  length_q;
	logic [9:0]  scale_q;
	logic [7:0]  offset_q;

	logic [EW-1:0] mem [TABLE_DEPTH];
	logic [EW-1:0] rd_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;

	logic [SW-1:0]        sample_q;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        last_q;
	logic [IW-1:0]        last_calc;
	logic [SW-1:0]        old_raw_q;
	logic signed [TW-1:0] old_temp_q;
	logic signed [SW:0]   dx_q;
	logic signed [TW:0]   dt_q;
	logic [SW-1:0]        dmag_q;
	logic                 neg_q;
	logic [PW-1:0]        quo_q;
	logic [SW-1:0]        rem_q;
	logic [tti_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [23:0]          lin_q;
	logic signed [TW-1:0] res_q;
	logic                 off_q;
	logic                 m_tvalid_q;
	logic [TW-1:0]        m_tdata_q;
	logic                 m_tuser_q;

	logic                 in_acc;
	logic                 out_free;
	logic [SW-1:0]        in_raw;
	logic [TW-1:0]        in_temp;
	logic [SW-1:0]        in_sample;
	logic [5:0]           in_index;
	logic [SW-1:0]        new_raw;
	logic signed [TW-1:0] new_temp;
	logic signed [SW:0]   den;
	logic signed [SW:0]   den_abs;
	logic signed [PW-1:0] prod;
	logic [SW:0]          trial;
	logic                 ge;
	logic signed [PW:0]   q_signed;
	logic signed [PW+1:0] sum;
	logic signed [TW-1:0] sat;
	logic signed [TW-1:0] lin_res;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign in_index  = s_tdata[5:0];
	assign in_raw    = s_tdata[19:6];
	assign in_temp   = s_tdata[35:20];
	assign in_sample = s_tdata[49:36];

	assign new_raw  = rd_q[SW-1:0];
	assign new_temp = $signed(rd_q[EW-1:SW]);
	assign den      = $signed({1'b0, new_raw}) - $signed({1'b0, old_raw_q});
	assign den_abs  = den[SW] ? -den : den;
	assign prod     = dx_q * dt_q;
	assign trial    = {rem_q, quo_q[PW-1]};
	assign ge       = trial >= {1'b0, dmag_q};
	assign q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign sum      = PW'(0) + $signed({{(PW+2-TW){old_temp_q[TW-1]}}, old_temp_q})
		+ $signed({q_signed[PW], q_signed});
	assign lin_res  = $signed({1'b0, lin_q[23:9]}) - $signed({5'b0, offset_q, 3'b000});

	always_comb begin
		if (sum > $signed({{(PW+2-TW){1'b0}}, tti_pkg::TEMP_MAX})) begin
			sat = tti_pkg::TEMP_MAX;
		end else if (sum < $signed({{(PW+2-TW){1'b1}}, tti_pkg::TEMP_MIN})) begin
			sat = tti_pkg::TEMP_MIN;
		end else begin
			sat = sum[TW-1:0];
		end
	end

	always_comb begin
		if (length_q < 7'd2) begin
			last_calc = IW'(1);
		end else if (32'(length_q) > TABLE_DEPTH) begin
			last_calc = IW'(TABLE_DEPTH - 1);
		end else begin
			last_calc = IW'(length_q - 7'd1);
		end
	end

	always_comb begin
		wr_en   = in_acc && (s_tuser == tti_pkg::KIND_WRITE) && (32'(in_index) < TABLE_DEPTH);
		wr_addr = IW'(in_index);
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				rd_en = in_acc && (s_tuser == tti_pkg::KIND_CONVERT)
					&& (mode_q == tti_pkg::MODE_TABLE);
			end
			ST_FIRST: begin
				rd_en   = 1'b1;
				rd_addr = IW'(1);
			end
			ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = idx_q + IW'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {in_temp, in_raw};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tti_pkg::MODE_TABLE;
			length_q <= 7'd2;
			scale_q  <= 10'd330;
			offset_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tti_pkg::REG_SENSOR_MODE:  mode_q   <= cfg_data[1:0];
				tti_pkg::REG_TABLE_LENGTH: length_q <= cfg_data[6:0];
				tti_pkg::REG_SCALE:        scale_q  <= cfg_data;
				tti_pkg::REG_OFFSET:       offset_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			sample_q   <= '0;
			idx_q      <= '0;
			last_q     <= '0;
			old_raw_q  <= '0;
			old_temp_q <= '0;
			dx_q       <= '0;
			dt_q       <= '0;
			dmag_q     <= '0;
			neg_q      <= 1'b0;
			quo_q      <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			lin_q      <= '0;
			res_q      <= '0;
			off_q      <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_tuser == tti_pkg::KIND_CONVERT)) begin
						sample_q <= in_sample;
						last_q   <= last_calc;
						off_q    <= 1'b0;
						case (mode_q)
							tti_pkg::MODE_FIXED: begin
								res_q   <= tti_pkg::FIXED_EIGHTHS;
								state_q <= ST_DONE;
							end
							tti_pkg::MODE_TABLE: begin
								state_q <= ST_FIRST;
							end
							tti_pkg::MODE_LINEAR: begin
								lin_q   <= 24'(in_sample * scale_q);
								state_q <= ST_LIN;
							end
							default: begin
								res_q   <= $signed({1'b0, in_sample, 1'b0});
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_FIRST: begin
					old_raw_q  <= new_raw;
					old_temp_q <= new_temp;
					idx_q      <= IW'(1);
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (new_raw > sample_q) begin
						dx_q   <= $signed({1'b0, sample_q}) - $signed({1'b0, old_raw_q});
						dt_q   <= $signed({new_temp[TW-1], new_temp})
							- $signed({old_temp_q[TW-1], old_temp_q});
						dmag_q <= den_abs[SW-1:0];
						neg_q  <= den[SW];
						if (den == '0) begin
							res_q   <= old_temp_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end else if (idx_q == last_q) begin
						res_q   <= new_temp;
						off_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						old_raw_q  <= new_raw;
						old_temp_q <= new_temp;
						idx_q      <= idx_q + IW'(1);
					end
				end
				ST_MUL: begin
					neg_q   <= neg_q ^ prod[PW-1];
					quo_q   <= prod[PW-1] ? PW'(-prod) : PW'(prod);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? SW'(trial - {1'b0, dmag_q}) : trial[SW-1:0];
					quo_q <= {quo_q[PW-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_q   <= sat;
					state_q <= ST_DONE;
				end
				ST_LIN: begin
					res_q   <= lin_res;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						m_tuser_q  <= off_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("table read and write in the same cycle");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dmag_q != '0))
		else $error("divider running with zero divisor");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= last_q))
		else $error("table walk past last entry");

	a_convert_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (s_tuser == tti_pkg::KIND_CONVERT)) |=> (state_q != ST_IDLE))
		else $error("conversion request dropped");

	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (s_tuser == tti_pkg::KIND_WRITE)) |=> (state_q == ST_IDLE))
		else $error("table write started a conversion");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the thermistor table interpolator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [15:0] temp;
		logic               off_table;
	} temp_result_t;

	typedef struct {
		logic [1:0] mode;
		logic [6:0] length;
		logic [9:0] scale;
		logic [7:0] offset;
	} conv_setup_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [tti_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [tti_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tuser;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [tti_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tti_pkg::CFG_DATA_W-1:0] cfg_data;

	conv_setup_t        setup;
	logic [13:0]        tab_raw [TABLE_DEPTH];
	logic signed [15:0] tab_temp [TABLE_DEPTH];
	temp_result_t       pending_temps [$];

	int          errors = 0;
	int          idle_odds = 6;
	int          rx_idle = 0;
	bit          rx_hold = 1'b0;
	int unsigned cycle_count = 0;

	thermistor_table_interpolator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[thermistor_table_interpolator_top] ERROR");
			$finish;
		end
	end

	function automatic temp_result_t predict_temperature(logic [13:0] reading);
		temp_result_t r;
		longint acc, x, sc, ofs, lo_raw, lo_temp, hi_raw, hi_temp;
		int n;
		bit found;
		r.off_table = 1'b0;
		x = longint'(reading);
		sc = longint'(setup.scale);
		ofs = longint'(setup.offset);
		acc = 0;
		case (setup.mode)
		tti_pkg::MODE_FIXED: acc = longint'(tti_pkg::FIXED_EIGHTHS);
		tti_pkg::MODE_TABLE: begin
			n = int'(setup.length);
			if (n < 2) n = 2;
			if (n > TABLE_DEPTH) n = TABLE_DEPTH;
			lo_raw = longint'(tab_raw[0]);
			lo_temp = longint'(tab_temp[0]);
			found = 1'b0;
			for (int i = 1; i < n && !found; i++) begin
				hi_raw = longint'(tab_raw[i]);
				hi_temp = longint'(tab_temp[i]);
				if (hi_raw > x) begin
					found = 1'b1;
					if (hi_raw == lo_raw)
						acc = lo_temp;
					else
						acc = lo_temp + (x - lo_raw) * (hi_temp - lo_temp) / (hi_raw - lo_raw);
				end else begin
					lo_raw = hi_raw;
					lo_temp = hi_temp;
				end
			end
			if (!found) begin
				acc = longint'(tab_temp[n-1]);
				r.off_table = 1'b1;
			end
		end
		tti_pkg::MODE_LINEAR: acc = ((x * sc * 8) >>> 12) - ofs * 8;
		default: acc = x * 2;
		endcase
		if (acc > 32767) acc = 32767;
		if (acc < -32768) acc = -32768;
		r.temp = acc[15:0];
		return r;
	endfunction

	function automatic logic [13:0] pick_reading();
		int base;
		case ($urandom_range(0, 3))
		0: return 14'($urandom_range(0, 16383));
		3: return ($urandom_range(0, 1) == 1) ? 14'h3fff : 14'h0000;
		default: begin
			base = int'(tab_raw[$urandom_range(0, TABLE_DEPTH - 1)]);
			base = base + int'($urandom_range(0, 6)) - 3;
			if (base < 0) base = 0;
			if (base > 16383) base = 16383;
			return 14'(base);
		end
		endcase
	endfunction

	task automatic flag_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	always @(posedge clk) begin : rx_side
		temp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_temps.size() == 0) begin
				flag_mismatch($sformatf("unexpected result temp %0d off %0b",
					$signed(m_tdata), m_tuser));
			end else begin
				want = pending_temps.pop_front();
				if (m_tdata !== want.temp)
					flag_mismatch($sformatf("temp_eighths got %0d want %0d",
						$signed(m_tdata), want.temp));
				if (m_tuser !== want.off_table)
					flag_mismatch($sformatf("off_table got %0b want %0b",
						m_tuser, want.off_table));
			end
		end
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else if (rx_idle > 0) begin
			rx_idle--;
			m_tready <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			rx_idle = $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_request(logic [0:0] kind, logic [5:0] idx, logic [13:0] raw,
			logic signed [15:0] temp, logic [13:0] reading);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'd0, reading, temp, raw, idx};
		do @(posedge clk); while (!s_tready);
		if (kind == tti_pkg::KIND_WRITE) begin
			tab_raw[idx] = raw;
			tab_temp[idx] = temp;
		end else begin
			pending_temps.push_back(predict_temperature(reading));
		end
	endtask

	task automatic store_entry(logic [5:0] idx, logic [13:0] raw, logic signed [15:0] temp);
		send_request(tti_pkg::KIND_WRITE, idx, raw, temp, 14'($urandom_range(0, 16383)));
	endtask

	task automatic convert(logic [13:0] reading);
		send_request(tti_pkg::KIND_CONVERT, 6'($urandom_range(0, 63)),
			14'($urandom_range(0, 16383)), 16'($urandom_range(0, 65535)), reading);
	endtask

	task automatic drain(int tail);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_temps.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic set_reg(logic [tti_pkg::CFG_IDX_W-1:0] index,
			logic [tti_pkg::CFG_DATA_W-1:0] value);
		drain(16);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
		tti_pkg::REG_SENSOR_MODE:  setup.mode = value[1:0];
		tti_pkg::REG_TABLE_LENGTH: setup.length = value[6:0];
		tti_pkg::REG_SCALE:        setup.scale = value[9:0];
		default:                   setup.offset = value[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic load_table();
		int raw_acc, temp_acc;
		bit rising;
		raw_acc = int'($urandom_range(0, 200));
		temp_acc = int'($urandom_range(0, 65535)) - 32768;
		rising = 1'($urandom_range(0, 1));
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			store_entry(6'(i), 14'(raw_acc), 16'(temp_acc));
			raw_acc += ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 500));
			if (raw_acc > 16383) raw_acc = 16383;
			temp_acc += rising ? int'($urandom_range(0, 900)) : -int'($urandom_range(0, 900));
			if (temp_acc > 32767) temp_acc = 32767;
			if (temp_acc < -32768) temp_acc = -32768;
		end
	endtask

	task automatic test_reset_defaults();
		store_entry(6'd0, 14'd0, tti_pkg::TEMP_MIN);
		store_entry(6'd1, 14'd16383, tti_pkg::TEMP_MAX);
		convert(14'd0);
		convert(14'd8191);
		convert(14'd16382);
		convert(14'd16383);
	endtask

	task automatic test_other_modes();
		set_reg(tti_pkg::REG_SENSOR_MODE, 10'(tti_pkg::MODE_FIXED));
		convert(14'd16383);
		set_reg(tti_pkg::REG_SENSOR_MODE, 10'(tti_pkg::MODE_QUARTER));
		convert(14'd16383);
		set_reg(tti_pkg::REG_SENSOR_MODE, 10'(tti_pkg::MODE_LINEAR));
		set_reg(tti_pkg::REG_SCALE, 10'd1023);
		convert(14'd16383);
		set_reg(tti_pkg::REG_SCALE, 10'd0);
		set_reg(tti_pkg::REG_OFFSET, 10'd255);
		convert(14'd16383);
		set_reg(tti_pkg::REG_SCALE, 10'd330);
		set_reg(tti_pkg::REG_OFFSET, 10'd12);
		convert(14'd4095);
	endtask

	task automatic test_table_corners();
		set_reg(tti_pkg::REG_SENSOR_MODE, 10'(tti_pkg::MODE_TABLE));
		set_reg(tti_pkg::REG_TABLE_LENGTH, 10'd4);
		store_entry(6'd0, 14'd1000, 16'sd200);
		store_entry(6'd1, 14'd1000, 16'sd400);
		store_entry(6'd2, 14'd3000, -16'sd100);
		store_entry(6'd3, 14'd2000, 16'sd50);
		convert(14'd500);
		convert(14'd1001);
		convert(14'd2999);
		convert(14'd3000);
		// length below two still walks the first pair
		set_reg(tti_pkg::REG_TABLE_LENGTH, 10'd1);
		store_entry(6'd0, 14'd5000, -16'sd40);
		store_entry(6'd1, 14'd4000, 16'sd1000);
		convert(14'd3000);
		convert(14'd4500);
		store_entry(6'd0, 14'd16383, tti_pkg::TEMP_MAX);
		store_entry(6'd1, 14'd16382, tti_pkg::TEMP_MIN);
		convert(14'd0);
	endtask

	task automatic test_random_phases();
		logic [1:0] mode;
		logic [6:0] length;
		for (int p = 0; p < 12; p++) begin
			case (p % 3)
			0: idle_odds = 3;
			1: idle_odds = 10;
			default: idle_odds = 0;
			endcase
			if (p == 0 || $urandom_range(0, 3) == 0)
				load_table();
			case (p % 4)
			1: mode = tti_pkg::MODE_LINEAR;
			3: mode = ((p / 4) % 2 == 1) ? tti_pkg::MODE_FIXED : tti_pkg::MODE_QUARTER;
			default: mode = tti_pkg::MODE_TABLE;
			endcase
			case (p / 2)
			0: length = 7'd2;
			1: length = 7'd64;
			2: length = 7'd0;
			3: length = 7'd1;
			4: length = 7'd127;
			default: length = 7'($urandom_range(3, 63));
			endcase
			set_reg(tti_pkg::REG_SENSOR_MODE, 10'(mode));
			set_reg(tti_pkg::REG_TABLE_LENGTH, 10'(length));
			case (p)
			1: begin
				set_reg(tti_pkg::REG_SCALE, 10'd1023);
				set_reg(tti_pkg::REG_OFFSET, 10'd0);
			end
			5: begin
				set_reg(tti_pkg::REG_SCALE, 10'd0);
				set_reg(tti_pkg::REG_OFFSET, 10'd255);
			end
			default: begin
				set_reg(tti_pkg::REG_SCALE, 10'($urandom_range(0, 1023)));
				set_reg(tti_pkg::REG_OFFSET, 10'($urandom_range(0, 255)));
			end
			endcase
			for (int k = 0; k < 80; k++) begin
				if ($urandom_range(0, 7) == 0)
					store_entry(6'($urandom_range(0, 63)), 14'($urandom_range(0, 16383)),
						16'($urandom_range(0, 65535)));
				else
					convert(pick_reading());
			end
		end
	endtask

	task automatic test_output_backpressure();
		idle_odds = 4;
		set_reg(tti_pkg::REG_SENSOR_MODE, 10'(tti_pkg::MODE_TABLE));
		set_reg(tti_pkg::REG_TABLE_LENGTH, 10'd64);
		fork
			begin
				rx_hold = 1'b1;
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		for (int k = 0; k < 24; k++)
			convert(pick_reading());
		drain(16);
		for (int k = 0; k < 10; k++)
			convert(pick_reading());
	endtask

	task automatic test_steady_stream();
		idle_odds = 0;
		for (int k = 0; k < 50; k++) begin
			if ($urandom_range(0, 9) == 0)
				store_entry(6'($urandom_range(0, 63)), 14'($urandom_range(0, 16383)),
					16'($urandom_range(0, 65535)));
			else
				convert(pick_reading());
		end
		set_reg(tti_pkg::REG_SENSOR_MODE, 10'(tti_pkg::MODE_LINEAR));
		for (int k = 0; k < 20; k++)
			convert(pick_reading());
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		setup = '{mode: tti_pkg::MODE_TABLE, length: 7'd2, scale: 10'd330, offset: 8'd0};
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tab_raw[i] = '0;
			tab_temp[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_other_modes();
		test_table_corners();
		test_random_phases();
		test_output_backpressure();
		test_steady_stream();
		drain(200);
		if (errors == 0)
			$display("[thermistor_table_interpolator_top] OK");
		else
			$display("[thermistor_table_interpolator_top] ERROR");
		$finish;
	end

endmodule
